[hw/rtl/frustum_extract_and_box_cull_unit_defines.svh]
// Assertion macros used by the frustum culling top level.
`ifndef FRUSTUM_EXTRACT_AND_BOX_CULL_UNIT_DEFINES_SVH
`define FRUSTUM_EXTRACT_AND_BOX_CULL_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define FBC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define FBC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/fbc_pkg.sv]
// Package with widths, codes and unit interface types for the frustum culling unit.
`default_nettype none
package fbc_pkg;
	localparam int VALUE_W = 32;
	localparam int FRAC_W = 16;
	localparam int RAW_W = VALUE_W + 1;
	localparam int QMAG_W = 51;
	localparam int DVD_W = QMAG_W + FRAC_W;
	localparam int DEN_W = VALUE_W + 1;
	localparam int SUM_W = 34;
	localparam int ROOT_W = 17;
	localparam int PROD_W = 2 * VALUE_W;

	localparam logic [1:0] ACT_WRITE = 2'd0;
	localparam logic [1:0] ACT_EXTRACT = 2'd1;
	localparam logic [1:0] ACT_BOX = 2'd2;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_DEGENERATE = 3'd1;
	localparam logic [2:0] ST_INVERTED = 3'd2;
	localparam logic [2:0] ST_NOT_READY = 3'd3;
	localparam logic [2:0] ST_OVERFLOW = 3'd4;

	typedef struct packed {
		logic start;
		logic [QMAG_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic [QMAG_W-1:0] quo;
	} div_rsp_t;

	typedef struct packed {
		logic start;
		logic [SUM_W-1:0] value;
	} sqrt_req_t;

	typedef struct packed {
		logic done;
		logic [ROOT_W-1:0] root;
	} sqrt_rsp_t;
endpackage
`default_nettype wire

[hw/rtl/fbc_div.sv]
// Restoring divider that forms round(num * 2^FRAC_W / den), one quotient bit per cycle.
`default_nettype none
module fbc_div (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire fbc_pkg::div_req_t req,
	output fbc_pkg::div_rsp_t rsp
);
	logic busy_q, done_q;
	logic [6:0] cnt_q;
	logic [fbc_pkg::DEN_W-1:0] den_q, rem_q;
	logic [fbc_pkg::DVD_W-1:0] dvd_q, quo;
	logic [fbc_pkg::DEN_W:0] trial, diff, rem2;
	logic ge, rnd;

	assign trial = {rem_q, dvd_q[fbc_pkg::DVD_W-1]};
	assign ge = trial >= {1'b0, den_q};
	assign diff = trial - {1'b0, den_q};
	assign rem2 = {rem_q, 1'b0};
	assign rnd = rem2 >= {1'b0, den_q};
	assign quo = dvd_q + fbc_pkg::DVD_W'(rnd);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'(fbc_pkg::DVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			den_q <= req.den;
			rem_q <= '0;
			dvd_q <= {req.num, fbc_pkg::FRAC_W'(0)};
		end else if (busy_q) begin
			rem_q <= ge ? diff[fbc_pkg::DEN_W-1:0] : trial[fbc_pkg::DEN_W-1:0];
			dvd_q <= {dvd_q[fbc_pkg::DVD_W-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo = quo[fbc_pkg::QMAG_W-1:0];
endmodule
`default_nettype wire

[hw/rtl/fbc_sqrt.sv]
// Digit-by-digit integer square root, one result bit per cycle.
`default_nettype none
module fbc_sqrt (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire fbc_pkg::sqrt_req_t req,
	output fbc_pkg::sqrt_rsp_t rsp
);
	logic busy_q, done_q;
	logic [4:0] cnt_q;
	logic [fbc_pkg::SUM_W-1:0] v_q, res_q, bit_q, t;
	logic ge;

	assign t = res_q + bit_q;
	assign ge = v_q >= t;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(fbc_pkg::ROOT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			v_q <= req.value;
			res_q <= '0;
			bit_q <= fbc_pkg::SUM_W'(1) << (fbc_pkg::SUM_W - 2);
		end else if (busy_q) begin
			v_q <= ge ? v_q - t : v_q;
			res_q <= ge ? (res_q >> 1) + bit_q : res_q >> 1;
			bit_q <= bit_q >> 2;
		end
	end

	assign rsp.done = done_q;
	assign rsp.root = res_q[fbc_pkg::ROOT_W-1:0];
endmodule
`default_nettype wire

[hw/rtl/fbc_mul.sv]
// Registered signed multiplier shared by the squaring and distance steps.
`default_nettype none
module fbc_mul (
	input  wire logic clk,
	input  wire logic signed [fbc_pkg::VALUE_W-1:0] a,
	input  wire logic signed [fbc_pkg::VALUE_W-1:0] b,
	output logic signed [fbc_pkg::PROD_W-1:0] prod_q
);
	always_ff @(posedge clk) begin
		prod_q <= fbc_pkg::PROD_W'(a) * fbc_pkg::PROD_W'(b);
	end
endmodule
`default_nettype wire

[hw/rtl/frustum_extract_and_box_cull_unit.sv]
// Top level of the frustum plane extraction and box culling unit.
//
// Channel   Direction  Handshake          Payload
// req       in         req_valid/ready    action, matrix_index, matrix_value, box_min_*, box_max_*
// rsp       out        rsp_valid/ready    visible, status
// apb       in         psel/penable       paddr, pwrite, pwdata, prdata, pready
//
// A write item, an unused action or a rejected box is answered straight from the idle state.
// A box test walks up to six planes, three products each, through one shared multiplier.
// An extraction runs each plane through the bit-serial divider and square root.
// Reset clears the matrix, the ready flag and the depth mode; the result register
// lets the next transfer be accepted in the cycle its result is taken.
`default_nettype none
`include "frustum_extract_and_box_cull_unit_defines.svh"
module frustum_extract_and_box_cull_unit (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic req_ready,
	input  wire logic [1:0] action,
	input  wire logic [3:0] matrix_index,
	input  wire logic signed [31:0] matrix_value,
	input  wire logic signed [31:0] box_min_x,
	input  wire logic signed [31:0] box_min_y,
	input  wire logic signed [31:0] box_min_z,
	input  wire logic signed [31:0] box_max_x,
	input  wire logic signed [31:0] box_max_y,
	input  wire logic signed [31:0] box_max_z,
	output logic rsp_valid,
	input  wire logic rsp_ready,
	output logic visible,
	output logic [2:0] status,
	input  wire logic psel,
	input  wire logic penable,
	input  wire logic pwrite,
	input  wire logic [2:0] paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	typedef enum logic [14:0] {
		S_IDLE      = 15'b000000000000001,
		S_EX_R3     = 15'b000000000000010,
		S_EX_RAW    = 15'b000000000000100,
		S_EX_CHK    = 15'b000000000001000,
		S_D1_GO     = 15'b000000000010000,
		S_D1_WAIT   = 15'b000000000100000,
		S_SQ_MUL    = 15'b000000001000000,
		S_SQ_ACC    = 15'b000000010000000,
		S_SQRT_GO   = 15'b000000100000000,
		S_SQRT_WAIT = 15'b000001000000000,
		S_D2_GO     = 15'b000010000000000,
		S_D2_WAIT   = 15'b000100000000000,
		S_BX_W      = 15'b001000000000000,
		S_BX_MUL    = 15'b010000000000000,
		S_BX_ACC    = 15'b100000000000000
	} state_t;

	state_t state_q;
	logic depth_range_q, planes_ready_q, bank_q;
	logic rsp_valid_q, visible_q;
	logic [2:0] status_q;
	logic [2:0] k_q;
	logic [1:0] c_q;
	logic signed [31:0] matrix_q [16];
	logic signed [31:0] plane_a_q [24];
	logic signed [31:0] plane_b_q [24];
	logic signed [31:0] r3_q;
	logic signed [fbc_pkg::RAW_W-1:0] raw_q [4];
	logic [fbc_pkg::DEN_W-1:0] s_q;
	logic q_neg_q [4];
	logic [fbc_pkg::QMAG_W-1:0] q_mag_q [4];
	logic [fbc_pkg::SUM_W-1:0] sum_q;
	logic [fbc_pkg::ROOT_W-1:0] len_q;
	logic signed [31:0] lo_q [3];
	logic signed [31:0] hi_q [3];
	logic signed [63:0] acc_q;

	logic [3:0] mat_addr;
	logic signed [31:0] mat_rd, pl_rd, box_v, mul_a, mul_b, sq_op, p_val;
	logic signed [fbc_pkg::RAW_W-1:0] r3_e, other_e, raw_new;
	logic [fbc_pkg::DEN_W-1:0] raw_mag, sel_mag;
	logic [4:0] pl_addr;
	logic signed [fbc_pkg::PROD_W-1:0] prod;
	logic signed [63:0] acc_next;
	logic inverted, p_ovf;
	fbc_pkg::div_req_t div_req;
	fbc_pkg::div_rsp_t div_rsp;
	fbc_pkg::sqrt_req_t sqrt_req;
	fbc_pkg::sqrt_rsp_t sqrt_rsp;

	assign mat_addr = (state_q == S_EX_R3) ? {c_q, 2'd3} : {c_q, k_q[2:1]};
	assign mat_rd = matrix_q[mat_addr];
	assign r3_e = fbc_pkg::RAW_W'(r3_q);
	assign other_e = fbc_pkg::RAW_W'(mat_rd);
	always_comb begin
		if (k_q == 3'd4 && depth_range_q) begin
			raw_new = other_e;
		end else if (k_q[0]) begin
			raw_new = r3_e - other_e;
		end else begin
			raw_new = r3_e + other_e;
		end
	end
	assign raw_mag = raw_new[fbc_pkg::RAW_W-1] ? fbc_pkg::DEN_W'(-raw_new) : fbc_pkg::DEN_W'(raw_new);
	assign sel_mag = raw_q[c_q][fbc_pkg::RAW_W-1] ? fbc_pkg::DEN_W'(-raw_q[c_q])
		: fbc_pkg::DEN_W'(raw_q[c_q]);

	assign pl_addr = (state_q == S_BX_W) ? {k_q, 2'd3} : {k_q, c_q};
	assign pl_rd = bank_q ? plane_b_q[pl_addr] : plane_a_q[pl_addr];
	assign box_v = (pl_rd >= 0) ? hi_q[c_q] : lo_q[c_q];
	assign sq_op = {15'd0, q_mag_q[c_q][16:0]};
	assign mul_a = (state_q == S_SQ_MUL) ? sq_op : pl_rd;
	assign mul_b = (state_q == S_SQ_MUL) ? sq_op : box_v;
	assign acc_next = acc_q + prod;

	assign inverted = (box_min_x > box_max_x) || (box_min_y > box_max_y)
		|| (box_min_z > box_max_z);

	assign p_ovf = q_neg_q[c_q] ? (div_rsp.quo > fbc_pkg::QMAG_W'(64'h8000_0000))
		: (div_rsp.quo > fbc_pkg::QMAG_W'(64'h7FFF_FFFF));
	assign p_val = q_neg_q[c_q] ? -div_rsp.quo[31:0] : div_rsp.quo[31:0];

	assign div_req.start = (state_q == S_D1_GO) || (state_q == S_D2_GO);
	assign div_req.num = (state_q == S_D1_GO) ? fbc_pkg::QMAG_W'(sel_mag) : q_mag_q[c_q];
	assign div_req.den = (state_q == S_D1_GO) ? s_q : fbc_pkg::DEN_W'(len_q);
	assign sqrt_req.start = (state_q == S_SQRT_GO);
	assign sqrt_req.value = sum_q;

	fbc_div u_div (.clk(clk), .arst_n(arst_n), .req(div_req), .rsp(div_rsp));
	fbc_sqrt u_sqrt (.clk(clk), .arst_n(arst_n), .req(sqrt_req), .rsp(sqrt_rsp));
	fbc_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod_q(prod));

	assign req_ready = (state_q == S_IDLE) && (!rsp_valid_q || rsp_ready);
	assign rsp_valid = rsp_valid_q;
	assign visible = visible_q;
	assign status = status_q;
	assign pready = 1'b1;
	assign prdata = paddr[2] ? 32'd0 : {31'd0, depth_range_q};

	always_ff @(posedge clk) begin
		if (state_q == S_D2_WAIT && div_rsp.done && !p_ovf) begin
			if (bank_q) begin
				plane_a_q[pl_addr] <= p_val;
			end else begin
				plane_b_q[pl_addr] <= p_val;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			depth_range_q <= 1'b0;
			planes_ready_q <= 1'b0;
			bank_q <= 1'b0;
			rsp_valid_q <= 1'b0;
			visible_q <= 1'b0;
			status_q <= fbc_pkg::ST_OK;
			k_q <= '0;
			c_q <= '0;
			for (int i = 0; i < 16; i++) begin
				matrix_q[i] <= '0;
			end
		end else begin
			if (psel && penable && pwrite && !paddr[2]) begin
				depth_range_q <= pwdata[0];
			end
			if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_valid && req_ready) begin
						lo_q[0] <= box_min_x;
						lo_q[1] <= box_min_y;
						lo_q[2] <= box_min_z;
						hi_q[0] <= box_max_x;
						hi_q[1] <= box_max_y;
						hi_q[2] <= box_max_z;
						k_q <= '0;
						c_q <= '0;
						s_q <= '0;
						visible_q <= 1'b0;
						status_q <= fbc_pkg::ST_OK;
						if (action == fbc_pkg::ACT_WRITE) begin
							matrix_q[matrix_index] <= matrix_value;
							rsp_valid_q <= 1'b1;
						end else if (action == fbc_pkg::ACT_EXTRACT) begin
							state_q <= S_EX_R3;
						end else if (action == fbc_pkg::ACT_BOX) begin
							if (inverted) begin
								status_q <= fbc_pkg::ST_INVERTED;
								rsp_valid_q <= 1'b1;
							end else if (!planes_ready_q) begin
								status_q <= fbc_pkg::ST_NOT_READY;
								rsp_valid_q <= 1'b1;
							end else begin
								state_q <= S_BX_W;
							end
						end else begin
							rsp_valid_q <= 1'b1;
						end
					end
				end
				S_EX_R3: begin
					r3_q <= mat_rd;
					state_q <= S_EX_RAW;
				end
				S_EX_RAW: begin
					raw_q[c_q] <= raw_new;
					if (c_q != 2'd3 && raw_mag > s_q) begin
						s_q <= raw_mag;
					end
					c_q <= c_q + 2'd1;
					state_q <= (c_q == 2'd3) ? S_EX_CHK : S_EX_R3;
				end
				S_EX_CHK: begin
					if (s_q == '0) begin
						planes_ready_q <= 1'b0;
						status_q <= fbc_pkg::ST_DEGENERATE;
						rsp_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_D1_GO;
					end
				end
				S_D1_GO: begin
					state_q <= S_D1_WAIT;
				end
				S_D1_WAIT: begin
					if (div_rsp.done) begin
						q_neg_q[c_q] <= raw_q[c_q][fbc_pkg::RAW_W-1];
						q_mag_q[c_q] <= div_rsp.quo;
						c_q <= c_q + 2'd1;
						sum_q <= '0;
						state_q <= (c_q == 2'd3) ? S_SQ_MUL : S_D1_GO;
					end
				end
				S_SQ_MUL: begin
					state_q <= S_SQ_ACC;
				end
				S_SQ_ACC: begin
					sum_q <= sum_q + prod[fbc_pkg::SUM_W-1:0];
					if (c_q == 2'd2) begin
						c_q <= '0;
						state_q <= S_SQRT_GO;
					end else begin
						c_q <= c_q + 2'd1;
						state_q <= S_SQ_MUL;
					end
				end
				S_SQRT_GO: begin
					state_q <= S_SQRT_WAIT;
				end
				S_SQRT_WAIT: begin
					if (sqrt_rsp.done) begin
						len_q <= sqrt_rsp.root;
						state_q <= S_D2_GO;
					end
				end
				S_D2_GO: begin
					state_q <= S_D2_WAIT;
				end
				S_D2_WAIT: begin
					if (div_rsp.done) begin
						if (p_ovf) begin
							planes_ready_q <= 1'b0;
							status_q <= fbc_pkg::ST_OVERFLOW;
							rsp_valid_q <= 1'b1;
							state_q <= S_IDLE;
						end else if (c_q == 2'd3) begin
							c_q <= '0;
							s_q <= '0;
							if (k_q == 3'd5) begin
								bank_q <= ~bank_q;
								planes_ready_q <= 1'b1;
								rsp_valid_q <= 1'b1;
								state_q <= S_IDLE;
							end else begin
								k_q <= k_q + 3'd1;
								state_q <= S_EX_R3;
							end
						end else begin
							c_q <= c_q + 2'd1;
							state_q <= S_D2_GO;
						end
					end
				end
				S_BX_W: begin
					acc_q <= 64'(pl_rd) <<< fbc_pkg::FRAC_W;
					state_q <= S_BX_MUL;
				end
				S_BX_MUL: begin
					state_q <= S_BX_ACC;
				end
				S_BX_ACC: begin
					acc_q <= acc_next;
					if (c_q == 2'd2) begin
						c_q <= '0;
						if (acc_next < 0) begin
							rsp_valid_q <= 1'b1;
							state_q <= S_IDLE;
						end else if (k_q == 3'd5) begin
							visible_q <= 1'b1;
							rsp_valid_q <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							k_q <= k_q + 3'd1;
							state_q <= S_BX_W;
						end
					end else begin
						c_q <= c_q + 2'd1;
						state_q <= S_BX_MUL;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`FBC_ASSERT_NEXT(a_accept_leaves_idle_or_answers, req_valid && req_ready, rsp_valid_q || (state_q != S_IDLE), "accepted transfer produced neither work nor a result")
	`FBC_ASSERT_NOW(a_visible_only_ok, rsp_valid_q && visible_q, status_q == fbc_pkg::ST_OK, "visible result carries an error status")
	`FBC_ASSERT_NOW(a_div_done_when_waiting, div_rsp.done, (state_q == S_D1_WAIT) || (state_q == S_D2_WAIT), "divider finished outside a wait state")
	`FBC_ASSERT_NOW(a_box_needs_planes, state_q == S_BX_W, planes_ready_q, "box test running without valid planes")
endmodule
`default_nettype wire
